// ===== hw/rtl/bkpt_pkg.sv =====
// shared types and constants of the breakpoint table patcher
package bkpt_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned HITS_W = 32;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [WORD_W-1:0] ILLEGAL_OPCODE = 16'h4AFC;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_CHECK   = 2'd1,
    MODE_RESTORE = 2'd2,
    MODE_PATCH   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    RC_ADDED   = 3'd0,
    RC_PRESENT = 3'd1,
    RC_FULL    = 3'd2,
    RC_HIT     = 3'd3,
    RC_ILLEGAL = 3'd4,
    RC_WRITE   = 3'd5,
    RC_NOTHING = 3'd6
  } rc_e;

  typedef struct packed {
    logic              last;
    logic [HITS_W-1:0] hits;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] waddr;
    rc_e               code;
  } res_t;

endpackage

// ===== hw/rtl/breakpoint_table_patcher.sv =====
// breakpoint table patcher: sixteen-entry software breakpoint table with a scan sequencer
//
// One input transfer on the s_axis side carries a command: add a breakpoint,
// check a program counter, restore the saved words or patch the illegal opcode.
// Every command gives one or more result transfers on the m_axis side; tlast
// marks the final result of a command. The table is scanned one entry at a time
// through a single registered read port and a single address comparator, each
// entry first read into the port register and then compared. Add and check end
// in a single result transfer; restore and patch emit up to N memory writes (N
// entries in use), each held until it is taken, or a single nothing result
// when nothing is written.
// s_axis_tready_o is high only while no command is in progress, so the block
// works on one command at a time. When the receiver stalls, the pending result
// holds in the output register and the scan waits for it.
// Reset empties the table (the entry count goes to zero); the entry storage
// itself is not cleared since only entries below the count are ever used.
module breakpoint_table_patcher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // mode [1:0], address [33:2], memory_word [49:34], zero fill above
  input  logic [bkpt_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // result_code [2:0], write_address [34:3], write_data [50:35],
  // hit_count [82:51], zero fill above
  output logic [bkpt_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  localparam int unsigned IDX_W = bkpt_pkg::IDX_W;
  localparam int unsigned CNT_W = bkpt_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_EVAL  = 6'b000100,
    S_MISS  = 6'b001000,
    S_TAIL  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             hold_v_q, hold_v_d;
  logic [bkpt_pkg::ADDR_W-1:0] hold_addr_q, hold_addr_d;
  logic [bkpt_pkg::WORD_W-1:0] hold_word_q, hold_word_d;
  bkpt_pkg::res_t   out_q, out_d;

  bkpt_pkg::mode_e  mode_q;
  logic [bkpt_pkg::ADDR_W-1:0] addr_q;
  logic [bkpt_pkg::WORD_W-1:0] word_q;

  logic [bkpt_pkg::ADDR_W-1:0] addr_mem [bkpt_pkg::DEPTH];
  logic [bkpt_pkg::HITS_W-1:0] hits_mem [bkpt_pkg::DEPTH];
  logic [bkpt_pkg::WORD_W-1:0] word_mem [bkpt_pkg::DEPTH];
  logic [bkpt_pkg::ADDR_W-1:0] rd_addr_q;
  logic [bkpt_pkg::HITS_W-1:0] rd_hits_q;
  logic [bkpt_pkg::WORD_W-1:0] rd_word_q;

  logic                        wr_add, wr_hit;
  logic [bkpt_pkg::HITS_W-1:0] hit_val;
  logic                        match, is_end, cand, s_accept;
  bkpt_pkg::mode_e             in_mode;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode         = bkpt_pkg::mode_e'(s_axis_tdata_i[1:0]);

  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {5'b0, out_q.hits, out_q.wdata, out_q.waddr, out_q.code};

  assign hit_val = rd_hits_q + 1'b1;
  assign match   = (rd_addr_q == addr_q);
  assign is_end  = ((CNT_W'(idx_q) + 1'b1) == used_q);
  assign cand    = (mode_q == bkpt_pkg::MODE_RESTORE) || !match;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    idx_d       = idx_q;
    used_d      = used_q;
    hold_v_d    = hold_v_q;
    hold_addr_d = hold_addr_q;
    hold_word_d = hold_word_q;
    out_d       = out_q;
    wr_add      = 1'b0;
    wr_hit      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          idx_d    = '0;
          hold_v_d = 1'b0;
          if (used_q != '0) begin
            state_d = S_FETCH;
          end else if (in_mode == bkpt_pkg::MODE_ADD || in_mode == bkpt_pkg::MODE_CHECK) begin
            state_d = S_MISS;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_FETCH: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        case (mode_q) inside
          bkpt_pkg::MODE_ADD, bkpt_pkg::MODE_CHECK: begin
            if (match) begin
              out_d = '{last: 1'b1, hits: '0, wdata: '0, waddr: '0,
                        code: bkpt_pkg::RC_PRESENT};
              if (mode_q == bkpt_pkg::MODE_CHECK) begin
                out_d.code = bkpt_pkg::RC_HIT;
                out_d.hits = hit_val;
                wr_hit     = 1'b1;
              end
              ret_d   = S_IDLE;
              state_d = S_OUT;
            end else if (is_end) begin
              state_d = S_MISS;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_FETCH;
            end
          end
          default: begin
            // one write is held back so the final one can carry tlast
            state_d = is_end ? S_TAIL : S_FETCH;
            if (!is_end) begin
              idx_d = idx_q + 1'b1;
            end
            if (cand) begin
              if (hold_v_q) begin
                out_d = '{last: 1'b0, hits: '0, wdata: hold_word_q, waddr: hold_addr_q,
                          code: bkpt_pkg::RC_WRITE};
                ret_d   = is_end ? S_TAIL : S_FETCH;
                state_d = S_OUT;
              end
              hold_v_d    = 1'b1;
              hold_addr_d = rd_addr_q;
              hold_word_d = (mode_q == bkpt_pkg::MODE_RESTORE) ? rd_word_q
                                                               : bkpt_pkg::ILLEGAL_OPCODE;
            end
          end
        endcase
      end
      S_MISS: begin
        out_d = '{last: 1'b1, hits: '0, wdata: '0, waddr: '0, code: bkpt_pkg::RC_ILLEGAL};
        if (mode_q == bkpt_pkg::MODE_ADD) begin
          if (used_q == CNT_W'(bkpt_pkg::DEPTH)) begin
            out_d.code = bkpt_pkg::RC_FULL;
          end else begin
            out_d.code = bkpt_pkg::RC_ADDED;
            wr_add     = 1'b1;
            used_d     = used_q + 1'b1;
          end
        end
        ret_d   = S_IDLE;
        state_d = S_OUT;
      end
      S_TAIL: begin
        if (hold_v_q) begin
          out_d = '{last: 1'b1, hits: '0, wdata: hold_word_q, waddr: hold_addr_q,
                    code: bkpt_pkg::RC_WRITE};
        end else begin
          out_d = '{last: 1'b1, hits: '0, wdata: '0, waddr: '0, code: bkpt_pkg::RC_NOTHING};
        end
        ret_d   = S_IDLE;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      idx_q    <= '0;
      used_q   <= '0;
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      idx_q    <= idx_d;
      used_q   <= used_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_addr_q <= hold_addr_d;
    hold_word_q <= hold_word_d;
    out_q       <= out_d;
    if (s_accept) begin
      mode_q <= in_mode;
      addr_q <= s_axis_tdata_i[33:2];
      word_q <= s_axis_tdata_i[49:34];
    end
  end

  // entry storage: one registered read port at the scan index
  always_ff @(posedge clk_i) begin
    rd_addr_q <= addr_mem[idx_q];
    rd_hits_q <= hits_mem[idx_q];
    rd_word_q <= word_mem[idx_q];
    if (wr_add) begin
      addr_mem[used_q[IDX_W-1:0]] <= addr_q;
      hits_mem[used_q[IDX_W-1:0]] <= '0;
      word_mem[used_q[IDX_W-1:0]] <= word_q;
    end
    if (wr_hit) begin
      hits_mem[idx_q] <= hit_val;
    end
  end

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(bkpt_pkg::DEPTH))
    else $error("entry count exceeds table depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("command accepted while previous one in progress");

  a_nothing_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_q.code == bkpt_pkg::RC_NOTHING) |-> m_axis_tlast_o)
    else $error("empty result without tlast");

  a_out_excludes_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while result pending");

endmodule

// ===== dv/tb_breakpoint_table_patcher.sv =====
// self-checking testbench for the breakpoint table patcher
`timescale 1ns / 100ps

module tb_breakpoint_table_patcher;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RAND_PER_PHASE = 120;

  typedef struct {
    bkpt_pkg::mode_e             mode;
    logic [bkpt_pkg::ADDR_W-1:0] addr;
    logic [bkpt_pkg::WORD_W-1:0] word;
  } bkpt_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // mode [1:0], address [33:2], memory_word [49:34], zero fill above
  logic [bkpt_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // result_code [2:0], write_address [34:3], write_data [50:35], hit_count [82:51]
  logic [bkpt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  // predicted breakpoint table
  logic [bkpt_pkg::ADDR_W-1:0] bp_addr [bkpt_pkg::DEPTH];
  logic [bkpt_pkg::HITS_W-1:0] bp_hits [bkpt_pkg::DEPTH];
  logic [bkpt_pkg::WORD_W-1:0] bp_saved [bkpt_pkg::DEPTH];
  int unsigned                 bp_used = 0;

  bkpt_cmd_t                   pending_cmds [$];
  bkpt_pkg::res_t              expected_results [$];
  logic [bkpt_pkg::ADDR_W-1:0] stim_table [$];
  bkpt_cmd_t                   drv_cmd;
  bkpt_pkg::res_t              want;
  int unsigned                 tx_idle_pct = 0;
  int unsigned                 rx_stall_pct = 0;
  int unsigned                 error_count = 0;
  int unsigned                 cycle_count = 0;

  breakpoint_table_patcher DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bkpt_pkg::res_t mk_res(bkpt_pkg::rc_e code,
                                            logic [bkpt_pkg::ADDR_W-1:0] waddr,
                                            logic [bkpt_pkg::WORD_W-1:0] wdata,
                                            logic [bkpt_pkg::HITS_W-1:0] hits,
                                            logic last);
    bkpt_pkg::res_t r;
    r.code  = code;
    r.waddr = waddr;
    r.wdata = wdata;
    r.hits  = hits;
    r.last  = last;
    return r;
  endfunction

  // updates the table copy and queues every result the command produces
  task automatic predict_bkpt_results(input bkpt_cmd_t c);
    int idx;
    int total;
    int k;
    idx = -1;
    total = 0;
    k = 0;
    for (int i = 0; i < int'(bp_used); i++) begin
      if (idx < 0 && bp_addr[i] == c.addr) idx = i;
    end
    case (c.mode)
      bkpt_pkg::MODE_ADD: begin
        if (idx >= 0) begin
          expected_results.push_back(mk_res(bkpt_pkg::RC_PRESENT, '0, '0, '0, 1'b1));
        end else if (bp_used >= bkpt_pkg::DEPTH) begin
          expected_results.push_back(mk_res(bkpt_pkg::RC_FULL, '0, '0, '0, 1'b1));
        end else begin
          bp_addr[bp_used]  = c.addr;
          bp_hits[bp_used]  = '0;
          bp_saved[bp_used] = c.word;
          bp_used++;
          expected_results.push_back(mk_res(bkpt_pkg::RC_ADDED, '0, '0, '0, 1'b1));
        end
      end
      bkpt_pkg::MODE_CHECK: begin
        if (idx >= 0) begin
          bp_hits[idx] = bp_hits[idx] + 1'b1;
          expected_results.push_back(mk_res(bkpt_pkg::RC_HIT, '0, '0, bp_hits[idx], 1'b1));
        end else begin
          expected_results.push_back(mk_res(bkpt_pkg::RC_ILLEGAL, '0, '0, '0, 1'b1));
        end
      end
      default: begin
        // count the writes first so tlast can go on the final one
        for (int i = 0; i < int'(bp_used); i++) begin
          if (c.mode == bkpt_pkg::MODE_RESTORE || bp_addr[i] != c.addr) total++;
        end
        if (total == 0) begin
          expected_results.push_back(mk_res(bkpt_pkg::RC_NOTHING, '0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < int'(bp_used); i++) begin
            if (c.mode == bkpt_pkg::MODE_RESTORE) begin
              k++;
              expected_results.push_back(mk_res(bkpt_pkg::RC_WRITE, bp_addr[i], bp_saved[i],
                                                '0, k == total));
            end else if (bp_addr[i] != c.addr) begin
              k++;
              expected_results.push_back(mk_res(bkpt_pkg::RC_WRITE, bp_addr[i],
                                                bkpt_pkg::ILLEGAL_OPCODE, '0, k == total));
            end
          end
        end
      end
    endcase
  endtask

  function automatic bit in_stim_table(logic [bkpt_pkg::ADDR_W-1:0] a);
    foreach (stim_table[i]) begin
      if (stim_table[i] == a) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic queue_cmd(input bkpt_pkg::mode_e mode,
                           input logic [bkpt_pkg::ADDR_W-1:0] addr,
                           input logic [bkpt_pkg::WORD_W-1:0] word);
    bkpt_cmd_t c;
    c.mode = mode;
    c.addr = addr;
    c.word = word;
    if (mode == bkpt_pkg::MODE_ADD && !in_stim_table(addr) &&
        stim_table.size() < bkpt_pkg::DEPTH) begin
      stim_table.push_back(addr);
    end
    pending_cmds.push_back(c);
  endtask

  function automatic logic [bkpt_pkg::ADDR_W-1:0] fresh_addr();
    logic [bkpt_pkg::ADDR_W-1:0] a;
    a = $urandom();
    while (in_stim_table(a)) a = $urandom();
    return a;
  endfunction

  // an address in the table, one bit away from one, or anything at all
  function automatic logic [bkpt_pkg::ADDR_W-1:0] pick_addr(int unsigned hit_pct);
    logic [bkpt_pkg::ADDR_W-1:0] a;
    int unsigned r;
    r = $urandom_range(99);
    if (stim_table.size() == 0) return $urandom();
    a = stim_table[$urandom_range(stim_table.size() - 1)];
    if (r < hit_pct) return a;
    if (r < hit_pct + (100 - hit_pct) / 2) begin
      return a ^ (32'h1 << $urandom_range(bkpt_pkg::ADDR_W - 1));
    end
    return $urandom();
  endfunction

  task automatic queue_random_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) begin
      queue_cmd(bkpt_pkg::MODE_ADD, pick_addr(50), bkpt_pkg::WORD_W'($urandom()));
    end else if (r < 60) begin
      queue_cmd(bkpt_pkg::MODE_CHECK, pick_addr(70), bkpt_pkg::WORD_W'($urandom()));
    end else if (r < 75) begin
      queue_cmd(bkpt_pkg::MODE_RESTORE, $urandom(), bkpt_pkg::WORD_W'($urandom()));
    end else begin
      queue_cmd(bkpt_pkg::MODE_PATCH, pick_addr(60), bkpt_pkg::WORD_W'($urandom()));
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_bkpt_results(drv_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          drv_cmd = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, drv_cmd.word, drv_cmd.addr, drv_cmd.mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: code %0d", m_axis_tdata[2:0]);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[2:0] != want.code) begin
            $error("result_code: expected %0d, actual %0d", want.code, m_axis_tdata[2:0]);
            error_count++;
          end
          if (m_axis_tdata[34:3] != want.waddr) begin
            $error("write_address: expected %h, actual %h", want.waddr, m_axis_tdata[34:3]);
            error_count++;
          end
          if (m_axis_tdata[50:35] != want.wdata) begin
            $error("write_data: expected %h, actual %h", want.wdata, m_axis_tdata[50:35]);
            error_count++;
          end
          if (m_axis_tdata[82:51] != want.hits) begin
            $error("hit_count: expected %0d, actual %0d", want.hits, m_axis_tdata[82:51]);
            error_count++;
          end
          if (m_axis_tlast != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_breakpoint_table_patcher NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table corners, then entries at address zero and at all ones
    queue_cmd(bkpt_pkg::MODE_RESTORE, '0, '0);
    queue_cmd(bkpt_pkg::MODE_PATCH, '1, '1);
    queue_cmd(bkpt_pkg::MODE_CHECK, '0, '0);
    queue_cmd(bkpt_pkg::MODE_ADD, '0, '0);
    queue_cmd(bkpt_pkg::MODE_PATCH, '0, '0);
    queue_cmd(bkpt_pkg::MODE_PATCH, 32'h0000_1234, '0);
    queue_cmd(bkpt_pkg::MODE_ADD, '0, '1);
    queue_cmd(bkpt_pkg::MODE_CHECK, '0, '0);
    queue_cmd(bkpt_pkg::MODE_CHECK, '0, '0);
    queue_cmd(bkpt_pkg::MODE_ADD, '1, '1);
    queue_cmd(bkpt_pkg::MODE_RESTORE, '0, '0);
    // fill the table, overflow it, patch around the top address
    repeat (bkpt_pkg::DEPTH - 2) begin
      queue_cmd(bkpt_pkg::MODE_ADD, fresh_addr(), bkpt_pkg::WORD_W'($urandom()));
    end
    queue_cmd(bkpt_pkg::MODE_ADD, fresh_addr(), bkpt_pkg::WORD_W'($urandom()));
    queue_cmd(bkpt_pkg::MODE_PATCH, '1, '0);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      repeat (RAND_PER_PHASE) queue_random_cmd();
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_breakpoint_table_patcher OK");
    end else begin
      $display("tb_breakpoint_table_patcher NOT OK");
    end
    $finish;
  end

endmodule
